### hw/rtl/zpg_pkg.sv
package zpg_pkg;

  // Signed Q1.15 sine sample shared by the table and the color stage.
  typedef logic signed [15:0] sine_t;

  // Width of the kept phase: turns scaled by 2^-40; the top SINE_ADDR_BITS bits of the sum address the sine table.
  localparam int PHASE_W = 40;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_X_ORIGIN  = 3'd0,
    REG_Y_ORIGIN  = 3'd1,
    REG_GAIN_X    = 3'd2,
    REG_GAIN_Y    = 3'd3,
    REG_COLOR_ONE = 3'd4,
    REG_COLOR_TWO = 3'd5,
    REG_MODE      = 3'd6
  } cfg_reg_t;

  // Color modes.
  localparam logic MODE_BLEND     = 1'b0;
  localparam logic MODE_THRESHOLD = 1'b1;

endpackage

### hw/rtl/zpg_sine_rom.sv
module zpg_sine_rom import zpg_pkg::*; #(
  parameter int ADDR_BITS = 10
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [ADDR_BITS-1:0] addr,
  output sine_t                data
);

  localparam int DEPTH = 1 << ADDR_BITS;
  localparam int QBITS = ADDR_BITS - 2;
  localparam logic [63:0] QSIZE = 64'd1 << QBITS;

  localparam logic [63:0] Q30_HALF = 64'd536870912;
  localparam logic [63:0] SIN_C1 = 64'd1686629713;
  localparam logic [63:0] SIN_C3 = 64'd693598668;
  localparam logic [63:0] SIN_C5 = 64'd85569306;
  localparam logic [63:0] SIN_C7 = 64'd5026995;
  localparam logic [63:0] SIN_C9 = 64'd172272;
  localparam logic [63:0] MAG_MAX = 64'd32767;

  typedef sine_t rom_t [DEPTH];

  // Quarter-wave sine as an odd polynomial in Q30, Horner form with truncating shifts.
  function automatic sine_t sine_entry(input logic [63:0] k);
    logic [63:0] r;
    logic [63:0] pos;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] m;
    logic [1:0]  quad;
    sine_t       mag;
    quad = 2'((k >> QBITS) & 64'd3);
    r    = k & (QSIZE - 64'd1);
    pos  = quad[0] ? (QSIZE - r) : r;
    x    = pos << (30 - QBITS);
    x2   = (x * x) >> 30;
    p    = SIN_C9;
    p    = SIN_C7 - ((x2 * p) >> 30);
    p    = SIN_C5 - ((x2 * p) >> 30);
    p    = SIN_C3 - ((x2 * p) >> 30);
    p    = SIN_C1 - ((x2 * p) >> 30);
    m    = ((((x * p) >> 30) * MAG_MAX) + Q30_HALF) >> 30;
    if (m > MAG_MAX) begin
      m = MAG_MAX;
    end
    mag = sine_t'(m[15:0]);
    return quad[1] ? -mag : mag;
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int i = 0; i < DEPTH; i++) begin
      t[i] = sine_entry(64'(i));
    end
    return t;
  endfunction

  localparam rom_t ROM_DATA = build_rom();

  always_ff @(posedge clk) begin
    if (en) begin
      data <= ROM_DATA[addr];
    end
  end

endmodule

### hw/rtl/zone_plate_pixel_generator_top.sv
// Zone-plate pixel generator. Each transfer on the slave stream carries one pixel
// coordinate (column in the low bits, row above it) and yields exactly one transfer on the
// master stream carrying that pixel's red, green and blue bytes. The pattern phase is
// gain_x*dx^2 + gain_y*dy^2 with dx = 2*column - x_origin and dy = y_origin - 2*row in
// half pixels; the fraction of a turn addresses a sine table, and the sine either blends
// color_one and color_two (mode 0) or picks one of them by its sign (mode 1). The block
// takes one pixel per clock unless the output stalls and holds six pixels in flight:
// coordinate offsets, squaring, gain multiplication, phase sum, sine table read and color
// blend or pick each own one register stage. Stalls from the master side reach every stage
// combinationally through the ready chain and bubbles are squeezed out, so the slave side
// keeps accepting while any stage is empty. Registers are written through
// the plain write port and should only change while no pixel is in flight.
module zone_plate_pixel_generator_top import zpg_pkg::*; #(
  parameter int COORD_BITS     = 12,
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  // Slave stream: column then row, zero filled to whole bytes.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]   s_tdata,
  // Master stream: red [7:0], green [15:8], blue [23:16].
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [23:0]                         m_tdata,
  // Configuration write port.
  input  logic                                cfg_wr_en,
  input  logic [2:0]                          cfg_index,
  input  logic [31:0]                         cfg_data
);

  // Offsets in half pixels need one bit above the wider of 2*column and the origin.
  localparam int DX_W  = ((COORD_BITS + 1 > 15) ? COORD_BITS + 1 : 15) + 1;
  localparam int SQ_W  = 2 * DX_W - 1;
  localparam int PRD_W = SQ_W + 32;
  localparam int NSTG  = 6;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic signed [14:0] x_origin;
  logic signed [14:0] y_origin;
  logic [31:0]        gain_x;
  logic [31:0]        gain_y;
  logic [23:0]        color_one;
  logic [23:0]        color_two;
  logic               mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin  <= '0;
      y_origin  <= '0;
      gain_x    <= '0;
      gain_y    <= '0;
      color_one <= '0;
      color_two <= 24'hFFFFFF;
      mode      <= MODE_BLEND;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_X_ORIGIN:  x_origin  <= signed'(cfg_data[14:0]);
        REG_Y_ORIGIN:  y_origin  <= signed'(cfg_data[14:0]);
        REG_GAIN_X:    gain_x    <= cfg_data;
        REG_GAIN_Y:    gain_y    <= cfg_data;
        REG_COLOR_ONE: color_one <= cfg_data[23:0];
        REG_COLOR_TWO: color_two <= cfg_data[23:0];
        REG_MODE:      mode      <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. A stage advances when it is empty or the stage after
  // it advances; the last stage advances when it is empty or its transfer completes.
  // ---------------------------------------------------------------------------
  logic [NSTG:1] vld;
  logic [NSTG:1] adv;

  always_comb begin
    adv[NSTG] = !vld[NSTG] || m_tready;
    for (int i = NSTG - 1; i >= 1; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign s_tready = adv[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= s_tvalid;
      end
      for (int i = 2; i <= NSTG; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: offsets from the origin in half pixels.
  // ---------------------------------------------------------------------------
  logic [COORD_BITS-1:0]  column;
  logic [COORD_BITS-1:0]  row;
  logic signed [DX_W-1:0] col2;
  logic signed [DX_W-1:0] row2;
  logic signed [DX_W-1:0] dx;
  logic signed [DX_W-1:0] dy;

  assign column = s_tdata[COORD_BITS-1:0];
  assign row    = s_tdata[2*COORD_BITS-1:COORD_BITS];
  assign col2   = signed'(DX_W'({column, 1'b0}));
  assign row2   = signed'(DX_W'({row, 1'b0}));

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      dx <= col2 - DX_W'(x_origin);
      dy <= DX_W'(y_origin) - row2;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: squares of the offsets.
  // ---------------------------------------------------------------------------
  logic signed [2*DX_W-1:0] dx_sq_full;
  logic signed [2*DX_W-1:0] dy_sq_full;
  logic [SQ_W-1:0]          sq_x;
  logic [SQ_W-1:0]          sq_y;

  assign dx_sq_full = dx * dx;
  assign dy_sq_full = dy * dy;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      sq_x <= dx_sq_full[SQ_W-1:0];
      sq_y <= dy_sq_full[SQ_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: gain products, kept modulo one turn.
  // ---------------------------------------------------------------------------
  logic [PRD_W-1:0]   prod_x;
  logic [PRD_W-1:0]   prod_y;
  logic [PHASE_W-1:0] phase_x;
  logic [PHASE_W-1:0] phase_y;

  assign prod_x = PRD_W'(gain_x) * PRD_W'(sq_x);
  assign prod_y = PRD_W'(gain_y) * PRD_W'(sq_y);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      phase_x <= prod_x[PHASE_W-1:0];
      phase_y <= prod_y[PHASE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: phase sum; the top bits of the turn fraction address the sine table.
  // ---------------------------------------------------------------------------
  logic [PHASE_W-1:0]        phase_sum;
  logic [SINE_ADDR_BITS-1:0] sine_addr;

  assign phase_sum = phase_x + phase_y;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      sine_addr <= phase_sum[PHASE_W-1 -: SINE_ADDR_BITS];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: sine table read.
  // ---------------------------------------------------------------------------
  sine_t sine;

  zpg_sine_rom #(
    .ADDR_BITS (SINE_ADDR_BITS)
  ) u_sine_rom (
    .clk  (clk),
    .en   (adv[5]),
    .addr (sine_addr),
    .data (sine)
  );

  // ---------------------------------------------------------------------------
  // Stage 6: color. Blend weights are u = sine + 32768 for color_two and
  // 65536 - u for color_one; each channel is truncated to eight bits.
  // ---------------------------------------------------------------------------
  logic [16:0] wt_two;
  logic [16:0] wt_one;
  logic [23:0] blend;
  logic [24:0] mix;
  logic [23:0] color;

  assign wt_two = 17'(signed'({sine[15], sine}) + 17'sd32768);
  assign wt_one = 17'd65536 - wt_two;

  always_comb begin
    mix = '0;
    for (int ch = 0; ch < 3; ch++) begin
      mix = 25'(color_one[8*ch +: 8]) * 25'(wt_one)
          + 25'(color_two[8*ch +: 8]) * 25'(wt_two);
      blend[8*ch +: 8] = mix[23:16];
    end
  end

  always_comb begin
    if (mode == MODE_THRESHOLD) begin
      color = (sine > 16'sd0) ? color_one : color_two;
    end else begin
      color = blend;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      m_tdata <= color;
    end
  end

  assign m_tvalid = vld[NSTG];

endmodule
